### design/gtg_pkg.sv
// Shared types, constants and helper functions for the go-to-goal PID steering block.
// Used by gtg_ctrl, gtg_datapath and go_to_goal_pid_steering_top; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package gtg_pkg;

    // Number of CORDIC rotations; values above 24 act as 24.
    localparam int CORDIC_STEPS = 16;
    localparam int CORDIC_RUN   = (CORDIC_STEPS > 24) ? 24 : CORDIC_STEPS;
    // One result bit per square-root step over a 34-bit radicand.
    localparam int SQRT_STEPS   = 17;
    localparam int RUN_STEPS    = (CORDIC_RUN > SQRT_STEPS) ? CORDIC_RUN : SQRT_STEPS;
    localparam int STEP_W       = 5;
    localparam int NUM_MULS     = 6;

    localparam logic signed [16:0] PI_Q12      = 17'sd12868;
    localparam logic signed [16:0] TWO_PI_Q12  = 17'sd25736;
    localparam logic signed [33:0] HALF_PI_Q30 = 34'sh06487ED51;

    localparam logic [2:0] REG_KP_LIN = 3'd0;
    localparam logic [2:0] REG_KI_LIN = 3'd1;
    localparam logic [2:0] REG_KD_LIN = 3'd2;
    localparam logic [2:0] REG_KP_ANG = 3'd3;
    localparam logic [2:0] REG_KI_ANG = 3'd4;
    localparam logic [2:0] REG_KD_ANG = 3'd5;
    localparam logic [2:0] REG_D_TOL  = 3'd6;
    localparam logic [2:0] REG_H_TOL  = 3'd7;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_SQX,
        OP_SQY,
        OP_LKI,
        OP_LKP,
        OP_LKD,
        OP_AKI,
        OP_AKP,
        OP_AKD
    } mul_op_t;

    typedef struct packed {
        logic              load;
        logic              run;
        logic [STEP_W-1:0] step;
        logic              err_calc;
        mul_op_t           mul_op;
        logic              wb;
    } gtg_cmd_t;

    // atan(2^-i) in signed Q4.30.
    function automatic logic signed [33:0] atan_q30(input logic [STEP_W-1:0] i);
        logic signed [33:0] v;
        begin
            unique case (i)
                5'd0:  v = 34'sh03243F6A8;
                5'd1:  v = 34'sh01DAC6705;
                5'd2:  v = 34'sh00FADBAFC;
                5'd3:  v = 34'sh007F56EA6;
                5'd4:  v = 34'sh003FEAB76;
                5'd5:  v = 34'sh001FFD55B;
                5'd6:  v = 34'sh000FFFAAA;
                5'd7:  v = 34'sh0007FFF55;
                5'd8:  v = 34'sh0003FFFEA;
                5'd9:  v = 34'sh0001FFFFD;
                5'd10: v = 34'sh0000FFFFF;
                5'd11: v = 34'sh00007FFFF;
                5'd12: v = 34'sh00003FFFF;
                5'd13: v = 34'sh00001FFFF;
                5'd14: v = 34'sh00000FFFF;
                5'd15: v = 34'sh000007FFF;
                5'd16: v = 34'sh000003FFF;
                5'd17: v = 34'sh000001FFF;
                5'd18: v = 34'sh000000FFF;
                5'd19: v = 34'sh0000007FF;
                5'd20: v = 34'sh0000003FF;
                5'd21: v = 34'sh0000001FF;
                5'd22: v = 34'sh0000000FF;
                5'd23: v = 34'sh00000007F;
                default: v = 34'sd0;
            endcase
            return v;
        end
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
        logic signed [31:0] r;
        begin
            if ((v[33:31] == 3'b000) || (v[33:31] == 3'b111))
                r = v[31:0];
            else if (v[33])
                r = 32'sh80000000;
            else
                r = 32'sh7FFFFFFF;
            return r;
        end
    endfunction

    // Single wrap of an angle difference into [-pi, pi].
    function automatic logic signed [16:0] wrap_once(input logic signed [16:0] e);
        logic signed [16:0] r;
        begin
            if (e > PI_Q12)
                r = e - TWO_PI_Q12;
            else if (e < -PI_Q12)
                r = e + TWO_PI_Q12;
            else
                r = e;
            return r;
        end
    endfunction

endpackage

`default_nettype wire

### design/gtg_ctrl.sv
// Sequencer of the go-to-goal PID steering block.
// Depends on gtg_pkg; drives gtg_datapath through a gtg_cmd_t command word.
`timescale 1ns / 1ps
`default_nettype none

module gtg_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output gtg_pkg::gtg_cmd_t     cmd
);
    import gtg_pkg::*;

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_SQX   = 9'b000000010,
        S_SQY   = 9'b000000100,
        S_SQSUM = 9'b000001000,
        S_RUN   = 9'b000010000,
        S_ERR   = 9'b000100000,
        S_MUL   = 9'b001000000,
        S_DRAIN = 9'b010000000,
        S_WB    = 9'b100000000
    } state_t;

    state_t            state_reg, state_next;
    logic [STEP_W-1:0] cnt_reg, cnt_next;
    logic              out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg;
        in_ready       = 1'b0;
        cmd            = '0;
        cmd.mul_op     = OP_NONE;
        cmd.step       = cnt_reg;
        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_SQX;
                end
            end
            S_SQX:
            begin
                cmd.mul_op = OP_SQX;
                state_next = S_SQY;
            end
            S_SQY:
            begin
                cmd.mul_op = OP_SQY;
                state_next = S_SQSUM;
            end
            S_SQSUM:
            begin
                cnt_next   = '0;
                state_next = S_RUN;
            end
            S_RUN:
            begin
                cmd.run = 1'b1;
                if (cnt_reg == STEP_W'(RUN_STEPS - 1))
                begin
                    cnt_next   = '0;
                    state_next = S_ERR;
                end
                else
                    cnt_next = cnt_reg + 1'b1;
            end
            S_ERR:
            begin
                cmd.err_calc = 1'b1;
                state_next   = S_MUL;
            end
            S_MUL:
            begin
                unique case (cnt_reg)
                    5'd0:    cmd.mul_op = OP_LKI;
                    5'd1:    cmd.mul_op = OP_LKP;
                    5'd2:    cmd.mul_op = OP_LKD;
                    5'd3:    cmd.mul_op = OP_AKI;
                    5'd4:    cmd.mul_op = OP_AKP;
                    default: cmd.mul_op = OP_AKD;
                endcase
                if (cnt_reg == STEP_W'(NUM_MULS - 1))
                begin
                    cnt_next   = '0;
                    state_next = S_DRAIN;
                end
                else
                    cnt_next = cnt_reg + 1'b1;
            end
            S_DRAIN:
            begin
                state_next = S_WB;
            end
            S_WB:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.wb         = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

### design/gtg_datapath.sv
// Datapath of the go-to-goal PID steering block: config registers, square root,
// CORDIC atan2, shared multiplier and PID state. Depends on gtg_pkg.
`timescale 1ns / 1ps
`default_nettype none

module gtg_datapath (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire gtg_pkg::gtg_cmd_t   cmd,
    input  wire logic                cfg_we,
    input  wire logic [2:0]          cfg_index,
    input  wire logic [15:0]         cfg_wdata,
    input  wire logic signed [15:0]  cur_x,
    input  wire logic signed [15:0]  cur_y,
    input  wire logic signed [14:0]  cur_heading,
    input  wire logic signed [15:0]  target_x,
    input  wire logic signed [15:0]  target_y,
    input  wire logic signed [14:0]  target_heading,
    output logic signed [31:0]       linear_cmd,
    output logic signed [31:0]       angular_cmd,
    output logic                     on_goal
);
    import gtg_pkg::*;

    logic [15:0] kp_lin_reg, ki_lin_reg, kd_lin_reg;
    logic [15:0] kp_ang_reg, ki_ang_reg, kd_ang_reg;
    logic [15:0] dtol_reg;
    logic [13:0] htol_reg;

    logic signed [16:0] dx_reg, dy_reg;
    logic signed [14:0] ch_reg;
    logic               zero_reg, head_ok_reg;
    logic signed [42:0] x_reg, y_reg;
    logic signed [33:0] z_reg;
    logic [34:0]        n_reg, res_reg;
    logic [16:0]        dist_reg, last_dist_reg;
    logic signed [15:0] err_reg, last_err_reg;
    logic signed [31:0] lin_int_reg, ang_int_reg;
    logic signed [27:0] acc_reg;
    logic signed [31:0] lin_res_reg, ang_res_reg;
    logic               on_reg;
    logic signed [35:0] prod_reg;
    mul_op_t            op_reg;
    logic signed [31:0] lin_out_reg, ang_out_reg;
    logic               on_out_reg;

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kp_lin_reg <= 16'd128;
            ki_lin_reg <= 16'd0;
            kd_lin_reg <= 16'd51;
            kp_ang_reg <= 16'd512;
            ki_ang_reg <= 16'd0;
            kd_ang_reg <= 16'd256;
            dtol_reg   <= 16'd26;
            htol_reg   <= 14'd410;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_KP_LIN: kp_lin_reg <= cfg_wdata;
                REG_KI_LIN: ki_lin_reg <= cfg_wdata;
                REG_KD_LIN: kd_lin_reg <= cfg_wdata;
                REG_KP_ANG: kp_ang_reg <= cfg_wdata;
                REG_KI_ANG: ki_ang_reg <= cfg_wdata;
                REG_KD_ANG: kd_ang_reg <= cfg_wdata;
                REG_D_TOL:  dtol_reg   <= cfg_wdata;
                REG_H_TOL:  htol_reg   <= cfg_wdata[13:0];
            endcase
        end
    end

    // Input capture and CORDIC pre-rotation.
    logic signed [16:0] dx_w, dy_w, gerr_w, gabs_w;
    logic signed [42:0] xi_w, yi_w;
    always_comb
    begin
        dx_w   = 17'(target_x) - 17'(cur_x);
        dy_w   = 17'(target_y) - 17'(cur_y);
        xi_w   = {{2{dx_w[16]}}, dx_w, 24'd0};
        yi_w   = {{2{dy_w[16]}}, dy_w, 24'd0};
        gerr_w = wrap_once(17'(target_heading) - 17'(cur_heading));
        gabs_w = gerr_w[16] ? -gerr_w : gerr_w;
    end

    // Square-root and CORDIC step.
    logic [34:0]        bit_w, sum_w;
    logic signed [42:0] xs_w, ys_w;
    logic               sqrt_en, cordic_en;
    always_comb
    begin
        bit_w     = 35'd1 << (6'd32 - {cmd.step, 1'b0});
        sum_w     = res_reg + bit_w;
        xs_w      = x_reg >>> cmd.step;
        ys_w      = y_reg >>> cmd.step;
        sqrt_en   = cmd.run && (cmd.step < STEP_W'(SQRT_STEPS));
        cordic_en = cmd.run && (cmd.step < STEP_W'(CORDIC_RUN));
    end

    // Heading error from the CORDIC angle.
    logic signed [33:0] zr_w;
    logic signed [15:0] bear_w;
    logic signed [16:0] err_w;
    always_comb
    begin
        zr_w   = z_reg + 34'sd131072;
        bear_w = zero_reg ? 16'sd0 : zr_w[33:18];
        err_w  = wrap_once(17'(bear_w) - 17'(ch_reg));
    end

    // Shared multiplier operands.
    logic signed [17:0] a_w, b_w;
    always_comb
    begin
        unique case (cmd.mul_op)
            OP_SQX:
            begin
                a_w = 18'(dx_reg);
                b_w = 18'(dx_reg);
            end
            OP_SQY:
            begin
                a_w = 18'(dy_reg);
                b_w = 18'(dy_reg);
            end
            OP_LKI:
            begin
                a_w = {1'b0, dist_reg};
                b_w = {2'b00, ki_lin_reg};
            end
            OP_LKP:
            begin
                a_w = {1'b0, dist_reg};
                b_w = {2'b00, kp_lin_reg};
            end
            OP_LKD:
            begin
                a_w = {1'b0, dist_reg} - {1'b0, last_dist_reg};
                b_w = {2'b00, kd_lin_reg};
            end
            OP_AKI:
            begin
                a_w = 18'(err_reg);
                b_w = {2'b00, ki_ang_reg};
            end
            OP_AKP:
            begin
                a_w = 18'(err_reg);
                b_w = {2'b00, kp_ang_reg};
            end
            OP_AKD:
            begin
                a_w = 18'(err_reg) - 18'(last_err_reg);
                b_w = {2'b00, kd_ang_reg};
            end
            default:
            begin
                a_w = '0;
                b_w = '0;
            end
        endcase
    end

    logic signed [27:0] sh_w;
    logic signed [33:0] lint_w, aint_w, lsum_w, asum_w;
    always_comb
    begin
        sh_w   = prod_reg[35:8];
        lint_w = 34'(lin_int_reg) + 34'(sh_w);
        aint_w = 34'(ang_int_reg) + 34'(sh_w);
        lsum_w = 34'(acc_reg) + 34'(sh_w) + 34'(lin_int_reg);
        asum_w = 34'(acc_reg) + 34'(sh_w) + 34'(ang_int_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_reg        <= OP_NONE;
            last_dist_reg <= '0;
            last_err_reg  <= '0;
            lin_int_reg   <= '0;
            ang_int_reg   <= '0;
        end
        else
        begin
            op_reg <= cmd.mul_op;
            unique case (op_reg)
                OP_LKI: lin_int_reg <= sat32(lint_w);
                OP_AKI: ang_int_reg <= sat32(aint_w);
                default: ;
            endcase
            if (cmd.wb)
            begin
                last_dist_reg <= dist_reg;
                last_err_reg  <= err_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= a_w * b_w;
        if (cmd.load)
        begin
            dx_reg      <= dx_w;
            dy_reg      <= dy_w;
            ch_reg      <= cur_heading;
            zero_reg    <= (dx_w == 17'sd0) && (dy_w == 17'sd0);
            head_ok_reg <= gabs_w < 17'(htol_reg);
            if (!dx_w[16])
            begin
                x_reg <= xi_w;
                y_reg <= yi_w;
                z_reg <= '0;
            end
            else if (!dy_w[16])
            begin
                x_reg <= yi_w;
                y_reg <= -xi_w;
                z_reg <= HALF_PI_Q30;
            end
            else
            begin
                x_reg <= -yi_w;
                y_reg <= xi_w;
                z_reg <= -HALF_PI_Q30;
            end
        end
        else if (cordic_en)
        begin
            if (!y_reg[42])
            begin
                x_reg <= x_reg + ys_w;
                y_reg <= y_reg - xs_w;
                z_reg <= z_reg + atan_q30(cmd.step);
            end
            else
            begin
                x_reg <= x_reg - ys_w;
                y_reg <= y_reg + xs_w;
                z_reg <= z_reg - atan_q30(cmd.step);
            end
        end
        unique case (op_reg)
            OP_SQX: n_reg <= prod_reg[34:0];
            OP_SQY:
            begin
                n_reg   <= n_reg + prod_reg[34:0];
                res_reg <= '0;
            end
            OP_LKP, OP_AKP: acc_reg <= sh_w;
            OP_LKD: lin_res_reg <= sat32(lsum_w);
            OP_AKD: ang_res_reg <= sat32(asum_w);
            default:
            begin
                if (sqrt_en)
                begin
                    if (n_reg >= sum_w)
                    begin
                        n_reg   <= n_reg - sum_w;
                        res_reg <= (res_reg >> 1) + bit_w;
                    end
                    else
                        res_reg <= res_reg >> 1;
                end
            end
        endcase
        if (cmd.err_calc)
        begin
            dist_reg <= res_reg[16:0];
            err_reg  <= err_w[15:0];
            on_reg   <= (res_reg[16:0] < {1'b0, dtol_reg}) && head_ok_reg;
        end
        if (cmd.wb)
        begin
            lin_out_reg <= lin_res_reg;
            ang_out_reg <= ang_res_reg;
            on_out_reg  <= on_reg;
        end
    end

    assign linear_cmd  = lin_out_reg;
    assign angular_cmd = ang_out_reg;
    assign on_goal     = on_out_reg;

endmodule

`default_nettype wire

### design/go_to_goal_pid_steering_top.sv
// Per input beat the block squares dx and dy, runs the bit-serial square root and the CORDIC
// on one shared step counter, computes the errors, makes six passes of one multiplier, drains
// and writes back; it takes no new input beat until that write-back.
// A new input beat is taken while the previous result beat still waits at the output; a
// second result then holds the block in its write-back state until the output frees up.
// Reset (rst_n, asynchronous, active low) loads the register defaults and clears PID state.
// Top level of the go-to-goal PID steering block; depends on gtg_pkg, gtg_ctrl, gtg_datapath.
`timescale 1ns / 1ps
`default_nettype none

module go_to_goal_pid_steering_top (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire logic signed [15:0]  cur_x,
    input  wire logic signed [15:0]  cur_y,
    input  wire logic signed [14:0]  cur_heading,
    input  wire logic signed [15:0]  target_x,
    input  wire logic signed [15:0]  target_y,
    input  wire logic signed [14:0]  target_heading,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output logic signed [31:0]       linear_cmd,
    output logic signed [31:0]       angular_cmd,
    output logic                     on_goal,
    input  wire logic                cfg_we,
    input  wire logic [2:0]          cfg_index,
    input  wire logic [15:0]         cfg_wdata
);
    import gtg_pkg::*;

    // The controller walks each beat through squaring, the shared square-root and
    // CORDIC iterations, the heading-error wrap and the six PID multiplies.
    gtg_cmd_t cmd;

    gtg_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd)
    );

    // The datapath holds the configuration registers, the PID state and the
    // output register that decouples the result beat from the next input beat.
    gtg_datapath u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .cur_x          (cur_x),
        .cur_y          (cur_y),
        .cur_heading    (cur_heading),
        .target_x       (target_x),
        .target_y       (target_y),
        .target_heading (target_heading),
        .linear_cmd     (linear_cmd),
        .angular_cmd    (angular_cmd),
        .on_goal        (on_goal)
    );

    // An accepted input beat keeps the block busy on the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("input taken twice in a row");

    // A waiting result beat is never overwritten by later work.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=>
            (out_valid && $stable(linear_cmd) && $stable(angular_cmd) && $stable(on_goal)))
        else $error("pending result changed");

    // A result appears only while a beat is being worked on, never from idle.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(!in_ready))
        else $error("result without work");

endmodule

`default_nettype wire
